>>> sv/cau_pkg.sv
// ---------------------------------------------------------------------------
// cau_pkg
// Shared types and codes of the complex arithmetic unit.
// ---------------------------------------------------------------------------
package cau_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int PORT_BITS     = 32;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIVZ = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                        command;
    logic signed [PORT_BITS-1:0] a_re;
    logic signed [PORT_BITS-1:0] a_im;
    logic signed [PORT_BITS-1:0] b_re;
    logic signed [PORT_BITS-1:0] b_im;
  } in_word_t;

  typedef struct packed {
    logic signed [PORT_BITS-1:0] res_re;
    logic signed [PORT_BITS-1:0] res_im;
    status_t                     status;
  } out_word_t;

  // control bits that travel with each word down the pipe
  typedef struct packed {
    logic valid;
    logic div_op;
    logic div_zero;
  } ctl_t;

endpackage

>>> sv/cau_front.sv
// ---------------------------------------------------------------------------
// cau_front
// Operand register, cross products, sums, sign-magnitude conversion and
// product rounding; sets up the divider for division words.
// ---------------------------------------------------------------------------
module cau_front import cau_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  in_word_t                       in_word,
  output ctl_t                           ctl_o,
  output logic [1:0]                     neg_o,
  output logic [1:0]                     big_o,
  output logic [1:0][WORD_BITS:0]        mag_o,
  output logic [1:0][2*WORD_BITS-1:0]    rem_o,
  output logic [1:0][WORD_BITS-1:0]      xlo_o,
  output logic [2*WORD_BITS-1:0]         d_o
);

  localparam int PW = 2 * WORD_BITS;
  localparam int MW = WORD_BITS + 1;
  localparam int SW = PW + 1;
  localparam int XW = PW + FRAC_BITS;
  localparam int CW = XW + WORD_BITS;
  localparam logic [PW:0] HALF = {{PW{1'b0}}, 1'b1} << (FRAC_BITS - 1);

  // stage 1: operands
  logic                        v1_r;
  cmd_t                        cmd1_r;
  logic signed [WORD_BITS-1:0] ar1_r, ai1_r, br1_r, bi1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r <= in_word.command;
      ar1_r  <= in_word.a_re[WORD_BITS-1:0];
      ai1_r  <= in_word.a_im[WORD_BITS-1:0];
      br1_r  <= in_word.b_re[WORD_BITS-1:0];
      bi1_r  <= in_word.b_im[WORD_BITS-1:0];
    end
  end

  // stage 2: products and plain sums
  logic                     v2_r;
  cmd_t                     cmd2_r;
  logic signed [PW-1:0]     prr2_r, pii2_r, pri2_r, pir2_r, pbb2_r, pcc2_r;
  logic signed [WORD_BITS:0] sre2_r, sim2_r;
  logic signed [WORD_BITS:0] ar_x, ai_x, br_x, bi_x;

  always_comb begin
    ar_x = MW'(ar1_r);
    ai_x = MW'(ai1_r);
    br_x = MW'(br1_r);
    bi_x = MW'(bi1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd2_r <= cmd1_r;
      prr2_r <= ar1_r * br1_r;
      pii2_r <= ai1_r * bi1_r;
      pri2_r <= ar1_r * bi1_r;
      pir2_r <= ai1_r * br1_r;
      pbb2_r <= br1_r * br1_r;
      pcc2_r <= bi1_r * bi1_r;
      if (cmd1_r == CMD_SUB) begin
        sre2_r <= ar_x - br_x;
        sim2_r <= ai_x - bi_x;
      end else begin
        sre2_r <= ar_x + br_x;
        sim2_r <= ai_x + bi_x;
      end
    end
  end

  // stage 3: combine cross products, divisor norm
  logic                 v3_r;
  cmd_t                 cmd3_r;
  logic signed [SW-1:0] s3_r [2];
  logic [PW-1:0]        d3_r;
  logic signed [SW-1:0] prr_x, pii_x, pri_x, pir_x, sre_x, sim_x;
  logic signed [SW-1:0] s3_nxt [2];

  always_comb begin
    prr_x = SW'(prr2_r);
    pii_x = SW'(pii2_r);
    pri_x = SW'(pri2_r);
    pir_x = SW'(pir2_r);
    sre_x = SW'(sre2_r);
    sim_x = SW'(sim2_r);
    case (cmd2_r)
      CMD_MUL: begin
        s3_nxt[0] = prr_x - pii_x;
        s3_nxt[1] = pri_x + pir_x;
      end
      CMD_DIV: begin
        // a times conjugate of b
        s3_nxt[0] = prr_x + pii_x;
        s3_nxt[1] = pir_x - pri_x;
      end
      default: begin
        s3_nxt[0] = sre_x;
        s3_nxt[1] = sim_x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd3_r  <= cmd2_r;
      s3_r[0] <= s3_nxt[0];
      s3_r[1] <= s3_nxt[1];
      d3_r    <= $unsigned(pbb2_r) + $unsigned(pcc2_r);
    end
  end

  // stage 4: sign and magnitude
  logic                v4_r;
  cmd_t                cmd4_r;
  logic                dz4_r;
  logic [1:0]          neg4_r;
  logic [1:0][PW-1:0]  mag4_r;
  logic [PW-1:0]       d4_r;
  logic [SW-1:0]       abs_c [2];

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      abs_c[p] = s3_r[p][SW-1] ? -s3_r[p] : s3_r[p];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd4_r <= cmd3_r;
      dz4_r  <= (d3_r == '0);
      d4_r   <= d3_r;
      for (int p = 0; p < 2; p++) begin
        neg4_r[p] <= s3_r[p][SW-1];
        mag4_r[p] <= abs_c[p][PW-1:0];
      end
    end
  end

  // stage 5: product rounding, divider setup
  logic                       v5_r, div5_r, dz5_r;
  logic [1:0]                 neg5_r, big5_r;
  logic [1:0][MW-1:0]         mag5_r;
  logic [1:0][PW-1:0]         rem5_r;
  logic [1:0][WORD_BITS-1:0]  xlo5_r;
  logic [PW-1:0]              d5_r;
  logic [XW-1:0]              x_c [2];
  logic [XW-1:0]              remx_c [2];
  logic [PW:0]                rnd_c [2];
  logic [PW:0]                rsh_c [2];
  logic [CW-1:0]              dc_c;
  logic [1:0]                 big_nxt;
  logic [1:0][MW-1:0]         mag_nxt;

  always_comb begin
    dc_c = {{FRAC_BITS{1'b0}}, d4_r, {WORD_BITS{1'b0}}};
    for (int p = 0; p < 2; p++) begin
      x_c[p]    = {mag4_r[p], {FRAC_BITS{1'b0}}};
      remx_c[p] = x_c[p] >> WORD_BITS;
      rnd_c[p]  = {1'b0, mag4_r[p]} + HALF;
      rsh_c[p]  = rnd_c[p] >> FRAC_BITS;
      case (cmd4_r)
        CMD_MUL: begin
          big_nxt[p] = |rsh_c[p][PW:MW];
          mag_nxt[p] = rsh_c[p][MW-1:0];
        end
        CMD_DIV: begin
          // quotient would not fit the divider's bits
          big_nxt[p] = ({{WORD_BITS{1'b0}}, x_c[p]} >= dc_c);
          mag_nxt[p] = '0;
        end
        default: begin
          big_nxt[p] = 1'b0;
          mag_nxt[p] = mag4_r[p][MW-1:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div5_r <= (cmd4_r == CMD_DIV);
      dz5_r  <= dz4_r;
      d5_r   <= d4_r;
      neg5_r <= neg4_r;
      big5_r <= big_nxt;
      mag5_r <= mag_nxt;
      for (int p = 0; p < 2; p++) begin
        rem5_r[p] <= remx_c[p][PW-1:0];
        xlo5_r[p] <= x_c[p][WORD_BITS-1:0];
      end
    end
  end

  assign ctl_o = '{valid: v5_r, div_op: div5_r, div_zero: dz5_r};
  assign neg_o = neg5_r;
  assign big_o = big5_r;
  assign mag_o = mag5_r;
  assign rem_o = rem5_r;
  assign xlo_o = xlo5_r;
  assign d_o   = d5_r;

endmodule

>>> sv/cau_div_step.sv
// ---------------------------------------------------------------------------
// cau_div_step
// One restoring division stage: produces quotient bit BIT for both parts.
// ---------------------------------------------------------------------------
module cau_div_step import cau_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int BIT       = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  ctl_t                           ctl_i,
  input  logic [1:0]                     neg_i,
  input  logic [1:0]                     big_i,
  input  logic [1:0][WORD_BITS:0]        mag_i,
  input  logic [1:0][2*WORD_BITS-1:0]    rem_i,
  input  logic [1:0][WORD_BITS-1:0]      xlo_i,
  input  logic [1:0][WORD_BITS-1:0]      q_i,
  input  logic [2*WORD_BITS-1:0]         d_i,
  output ctl_t                           ctl_o,
  output logic [1:0]                     neg_o,
  output logic [1:0]                     big_o,
  output logic [1:0][WORD_BITS:0]        mag_o,
  output logic [1:0][2*WORD_BITS-1:0]    rem_o,
  output logic [1:0][WORD_BITS-1:0]      xlo_o,
  output logic [1:0][WORD_BITS-1:0]      q_o,
  output logic [2*WORD_BITS-1:0]         d_o
);

  localparam int PW = 2 * WORD_BITS;

  logic                           valid_r, div_r, dz_r;
  logic [1:0]                     neg_r, big_r;
  logic [1:0][WORD_BITS:0]        mag_r;
  logic [1:0][PW-1:0]             rem_r, rem_nxt;
  logic [1:0][WORD_BITS-1:0]      xlo_r, q_r, q_nxt;
  logic [PW-1:0]                  d_r;
  logic [PW:0]                    t_c [2];
  logic [PW:0]                    df_c [2];
  logic [1:0]                     ge_c;

  always_comb begin
    q_nxt = q_i;
    for (int p = 0; p < 2; p++) begin
      t_c[p]         = {rem_i[p], xlo_i[p][BIT]};
      df_c[p]        = t_c[p] - {1'b0, d_i};
      ge_c[p]        = (t_c[p] >= {1'b0, d_i});
      rem_nxt[p]     = ge_c[p] ? df_c[p][PW-1:0] : t_c[p][PW-1:0];
      q_nxt[p][BIT]  = ge_c[p];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= ctl_i.div_op;
      dz_r  <= ctl_i.div_zero;
      neg_r <= neg_i;
      big_r <= big_i;
      mag_r <= mag_i;
      rem_r <= rem_nxt;
      xlo_r <= xlo_i;
      q_r   <= q_nxt;
      d_r   <= d_i;
    end
  end

  assign ctl_o = '{valid: valid_r, div_op: div_r, div_zero: dz_r};
  assign neg_o = neg_r;
  assign big_o = big_r;
  assign mag_o = mag_r;
  assign rem_o = rem_r;
  assign xlo_o = xlo_r;
  assign q_o   = q_r;
  assign d_o   = d_r;

endmodule

>>> sv/cau_back.sv
// ---------------------------------------------------------------------------
// cau_back
// Quotient rounding, saturation to the word range and status encoding.
// ---------------------------------------------------------------------------
module cau_back import cau_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  ctl_t                           ctl_i,
  input  logic [1:0]                     neg_i,
  input  logic [1:0]                     big_i,
  input  logic [1:0][WORD_BITS:0]        mag_i,
  input  logic [1:0][2*WORD_BITS-1:0]    rem_i,
  input  logic [1:0][WORD_BITS-1:0]      q_i,
  input  logic [2*WORD_BITS-1:0]         d_i,
  output logic                           valid_o,
  output out_word_t                      word_o
);

  localparam int MW = WORD_BITS + 1;
  localparam logic [MW-1:0] LIM = {{WORD_BITS{1'b0}}, 1'b1} << (WORD_BITS - 1);

  // stage 1: round quotient half away from zero
  logic               v1_r, div1_r, dz1_r;
  logic [1:0]         neg1_r, big1_r;
  logic [1:0][MW-1:0] m1_r, m_nxt;
  logic [1:0]         up_c;

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      up_c[p]  = ({rem_i[p], 1'b0} >= {1'b0, d_i});
      m_nxt[p] = ctl_i.div_op ? ({1'b0, q_i[p]} + MW'(up_c[p])) : mag_i[p];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div1_r <= ctl_i.div_op;
      dz1_r  <= ctl_i.div_zero;
      neg1_r <= neg_i;
      big1_r <= big_i;
      m1_r   <= m_nxt;
    end
  end

  // stage 2: saturate
  logic                        v2_r;
  out_word_t                   word2_r, word_nxt;
  logic [1:0]                  ovf_c;
  logic [MW-1:0]               sv_c [2];
  logic [MW-1:0]               tc_c [2];
  logic signed [WORD_BITS-1:0] rw_c [2];

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      if (neg1_r[p]) begin
        ovf_c[p] = big1_r[p] || (m1_r[p] > LIM);
        sv_c[p]  = ovf_c[p] ? LIM : m1_r[p];
        tc_c[p]  = -sv_c[p];
      end else begin
        ovf_c[p] = big1_r[p] || (m1_r[p] >= LIM);
        sv_c[p]  = ovf_c[p] ? (LIM - MW'(1)) : m1_r[p];
        tc_c[p]  = sv_c[p];
      end
      rw_c[p] = tc_c[p][WORD_BITS-1:0];
    end
    if (div1_r && dz1_r) begin
      word_nxt.res_re = '0;
      word_nxt.res_im = '0;
      word_nxt.status = ST_DIVZ;
    end else begin
      word_nxt.res_re = PORT_BITS'(rw_c[0]);
      word_nxt.res_im = PORT_BITS'(rw_c[1]);
      word_nxt.status = (|ovf_c) ? ST_OVF : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word2_r <= word_nxt;
    end
  end

  assign valid_o = v2_r;
  assign word_o  = word2_r;

endmodule

>>> sv/complex_arithmetic_unit_top.sv
// ---------------------------------------------------------------------------
// complex_arithmetic_unit_top
// Complex add, subtract, multiply and divide in signed fixed point.
// ---------------------------------------------------------------------------
// A new word is taken every cycle while the output queue has room. On its
// way out a word passes five front stages, one divider stage per quotient
// bit, two stages of rounding and saturation and a two-entry output queue.
// Every command goes through the same stages, so results come out in
// order. Products and quotients round half away from zero, every part
// saturates, and a zero divisor returns zero with its own status code.
module complex_arithmetic_unit_top import cau_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int PW = 2 * WORD_BITS;
  localparam int MW = WORD_BITS + 1;

  logic en;

  ctl_t                              ctl_s [WORD_BITS+1];
  logic [WORD_BITS:0][1:0]           neg_s, big_s;
  logic [WORD_BITS:0][1:0][MW-1:0]   mag_s;
  logic [WORD_BITS:0][1:0][PW-1:0]   rem_s;
  logic [WORD_BITS:0][1:0][WORD_BITS-1:0] xlo_s, q_s;
  logic [WORD_BITS:0][PW-1:0]        d_s;

  cau_front #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_word  (in_word),
    .ctl_o    (ctl_s[0]),
    .neg_o    (neg_s[0]),
    .big_o    (big_s[0]),
    .mag_o    (mag_s[0]),
    .rem_o    (rem_s[0]),
    .xlo_o    (xlo_s[0]),
    .d_o      (d_s[0])
  );

  assign q_s[0] = '0;

  for (genvar j = 0; j < WORD_BITS; j++) begin : g_div
    cau_div_step #(
      .WORD_BITS (WORD_BITS),
      .BIT       (WORD_BITS - 1 - j)
    ) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ctl_s[j]),
      .neg_i (neg_s[j]),
      .big_i (big_s[j]),
      .mag_i (mag_s[j]),
      .rem_i (rem_s[j]),
      .xlo_i (xlo_s[j]),
      .q_i   (q_s[j]),
      .d_i   (d_s[j]),
      .ctl_o (ctl_s[j+1]),
      .neg_o (neg_s[j+1]),
      .big_o (big_s[j+1]),
      .mag_o (mag_s[j+1]),
      .rem_o (rem_s[j+1]),
      .xlo_o (xlo_s[j+1]),
      .q_o   (q_s[j+1]),
      .d_o   (d_s[j+1])
    );
  end

  logic      bk_valid;
  out_word_t bk_word;

  cau_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_i   (ctl_s[WORD_BITS]),
    .neg_i   (neg_s[WORD_BITS]),
    .big_i   (big_s[WORD_BITS]),
    .mag_i   (mag_s[WORD_BITS]),
    .rem_i   (rem_s[WORD_BITS]),
    .q_i     (q_s[WORD_BITS]),
    .d_i     (d_s[WORD_BITS]),
    .valid_o (bk_valid),
    .word_o  (bk_word)
  );

  // two-entry output queue; the pipe moves only while it has room
  logic [1:0] cnt_r, cnt_nxt;
  out_word_t  e0_r, e1_r, e0_nxt, e1_nxt;
  logic       push, pop;

  assign en       = (cnt_r != 2'd2);
  assign in_stall = !en;
  assign push     = en && bk_valid;
  assign pop      = out_valid && !out_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    case ({push, pop})
      2'b01: begin
        e0_nxt  = e1_r;
        cnt_nxt = cnt_r - 2'd1;
      end
      2'b10: begin
        if (cnt_r == 2'd0) begin
          e0_nxt = bk_word;
        end else begin
          e1_nxt = bk_word;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          e0_nxt = bk_word;
        end else begin
          e0_nxt = e1_r;
          e1_nxt = bk_word;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_word  = e0_r;

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != 2'd2)
    else $error("word pushed into full output queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output queue count out of range");

  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == ST_DIVZ) |->
      (out_word.res_re == '0 && out_word.res_im == '0))
    else $error("divide by zero word carries nonzero result");

  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push && cnt_r == 2'd2) |=> (cnt_r == 2'd1 && out_word == $past(e1_r)))
    else $error("queued word lost on pop");

endmodule
